### rtl/efc_pkg.sv
package efc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] payload_length;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_BAD_TYPE = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_CRC  = 3'd3,
        ST_SHORT    = 3'd4
    } status_t;

    localparam logic [1:0] CFG_MAX_PAYLOAD   = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_TYPE = 2'd1;

    localparam logic [13:0] MAX_PAYLOAD_RESET   = 14'd1500;
    localparam logic [15:0] EXPECTED_TYPE_RESET = 16'h86dd;

    localparam int unsigned COUNT_FIELD_MAX = 16383;
    localparam logic [13:0] MIN_FRAME       = 14'd18;
    localparam logic [13:0] TRAILER_BYTES   = 14'd4;
    localparam logic [13:0] TYPE_HI_POS     = 14'd12;
    localparam logic [13:0] TYPE_LO_POS     = 14'd13;

    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    typedef struct packed {
        logic [31:0] crc;
        logic [31:0] trailer;
        logic [15:0] frame_type;
        logic [13:0] total;
    } frame_info_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/efc_frame_track.sv
module efc_frame_track
    import efc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  byte_item_t  item,
    output frame_info_t info
);

    localparam int unsigned CountLimitInt =
        (MAX_FRAME_BYTES < COUNT_FIELD_MAX) ? MAX_FRAME_BYTES : COUNT_FIELD_MAX;
    localparam logic [13:0] CountLimit = CountLimitInt[13:0];

    logic [31:0]      crc_reg,   crc_next;
    logic [3:0][7:0]  tail_reg,  tail_next;
    logic [13:0]      count_reg, count_next;
    logic [15:0]      type_reg,  type_next;

    logic [31:0] crc_step;
    logic [14:0] count_inc;
    logic [13:0] total;
    logic [15:0] type_step;

    always_comb
    begin
        crc_step  = (count_reg >= TRAILER_BYTES) ? crc_byte(crc_reg, tail_reg[0]) : crc_reg;
        count_inc = {1'b0, count_reg} + 15'd1;
        total     = (count_inc > {1'b0, CountLimit}) ? CountLimit : count_inc[13:0];
        type_step = type_reg;
        if (count_reg == TYPE_HI_POS)
        begin
            type_step = {item.data_byte, type_reg[7:0]};
        end
        else if (count_reg == TYPE_LO_POS)
        begin
            type_step = {type_reg[15:8], item.data_byte};
        end
        info = '{crc:        crc_step,
                 trailer:    {item.data_byte, tail_reg[3], tail_reg[2], tail_reg[1]},
                 frame_type: type_step,
                 total:      total};
    end

    always_comb
    begin
        crc_next   = crc_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        type_next  = type_reg;
        if (step)
        begin
            if (item.end_of_frame)
            begin
                crc_next   = CRC_INIT;
                tail_next  = '0;
                count_next = '0;
                type_next  = '0;
            end
            else
            begin
                crc_next   = crc_step;
                tail_next  = {item.data_byte, tail_reg[3], tail_reg[2], tail_reg[1]};
                count_next = total;
                type_next  = type_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            tail_reg  <= '0;
            count_reg <= '0;
            type_reg  <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            type_reg  <= type_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountLimit)
        else $error("byte count above its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.end_of_frame) |=> (count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= TRAILER_BYTES) |-> (crc_reg == CRC_INIT))
        else $error("crc advanced before the delay line filled");

endmodule

### rtl/efc_result.sv
module efc_result
    import efc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  frame_info_t  info,
    input  logic [13:0]  max_payload,
    input  logic [15:0]  expected_type,
    input  logic         result_ready,
    output logic         result_valid,
    output result_item_t result_word
);

    logic         valid_reg, valid_next;
    result_item_t word_reg;
    result_item_t word_next;
    status_t      status;
    logic [13:0]  payload;

    always_comb
    begin
        payload = '0;
        status  = ST_GOOD;
        if (info.total < MIN_FRAME)
        begin
            status = ST_SHORT;
        end
        else
        begin
            payload = info.total - MIN_FRAME;
            if (info.frame_type != expected_type)
            begin
                status = ST_BAD_TYPE;
            end
            else if (payload > max_payload)
            begin
                status = ST_BAD_LEN;
            end
            else if ((info.crc ^ CRC_INIT) != info.trailer)
            begin
                status = ST_BAD_CRC;
            end
        end
        word_next = '{status: status, payload_length: payload};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_word  = word_reg;

endmodule

### rtl/ethernet_frame_checker.sv
// Ethernet receive frame checker.
// byte channel: one frame byte per word in wire order from the destination
//   address onward; end_of_frame marks the last byte of the FCS.
// result channel: one word per frame, given for the end-marked byte only,
//   with status (good, bad type, bad length, bad crc, too short) and the
//   payload length (frame bytes minus header and FCS).
// cfg channel: index 0 writes max_payload, index 1 writes expected_type;
//   other indexes are ignored. Always ready; write only between frames.
// Path: the last byte is captured in the input register, then the CRC
//   update and checks load the result register, which drives result_valid.
// Throughput: one byte per cycle, set by the byte-wide CRC-32 update in
//   the single stage between input and result registers, but see Stall.
// Reset: max_payload returns to 1500, expected_type to 0x86dd, and the
//   frame state (CRC, delay line, count, ethertype) clears.
// Stall: while a result waits, non-final bytes keep flowing; a final
//   byte holds in the input register until the result is taken, and
//   byte_ready drops behind it.
module ethernet_frame_checker
    import efc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 16384
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  byte_item_t   byte_word,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_word,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic        stage_valid_reg, stage_valid_next;
    byte_item_t  stage_item_reg;
    logic [13:0] max_payload_reg, max_payload_next;
    logic [15:0] expected_type_reg, expected_type_next;
    logic        advance;
    logic        byte_accept;
    frame_info_t info;

    assign advance     = stage_valid_reg &&
                         (!stage_item_reg.end_of_frame || !result_valid || result_ready);
    assign byte_ready  = !stage_valid_reg || advance;
    assign byte_accept = byte_valid && byte_ready;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (byte_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        max_payload_next   = max_payload_reg;
        expected_type_next = expected_type_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_PAYLOAD:   max_payload_next   = cfg_data[13:0];
                CFG_EXPECTED_TYPE: expected_type_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            max_payload_reg   <= MAX_PAYLOAD_RESET;
            expected_type_reg <= EXPECTED_TYPE_RESET;
        end
        else
        begin
            stage_valid_reg   <= stage_valid_next;
            max_payload_reg   <= max_payload_next;
            expected_type_reg <= expected_type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            stage_item_reg <= byte_word;
        end
    end

    efc_frame_track #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_frame_track (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (stage_item_reg),
        .info  (info)
    );

    efc_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && stage_item_reg.end_of_frame),
        .info          (info),
        .max_payload   (max_payload_reg),
        .expected_type (expected_type_reg),
        .result_ready  (result_ready),
        .result_valid  (result_valid),
        .result_word   (result_word)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> byte_ready)
        else $error("input refused with empty stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_item_reg.end_of_frame && result_valid && !result_ready)
        |-> (!byte_ready && !advance))
        else $error("last byte advanced over a waiting result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_item_reg.end_of_frame) |=> result_valid)
        else $error("result lost after last byte");

endmodule
